[sv/single_source_shortest_paths_assert.svh]
// Assertion macros for the shortest-path block.
// Uses the clk and rst_n names of the including module; no other dependency.
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_ASSERT_SVH
`ifndef SYNTH
`define SSP_ASSERT(lbl, p) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (p)) \
    else $error("ssp assertion failed");
`define SSP_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ssp implication failed");
`else
`define SSP_ASSERT(lbl, p)
`define SSP_ASSERT_IMP(lbl, a, c)
`endif
`endif

[sv/ssp_pkg.sv]
// Shared types and constants of the shortest-path block.
// No dependencies.
`default_nettype none
package ssp_pkg;
  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES    = 256;
  localparam int WEIGHT_BITS  = 16;
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int DW  = 31;
  localparam logic [EW-1:0] NO_EDGE  = EW'(MAX_EDGES);
  localparam logic [DW-1:0] DIST_INF = {DW{1'b1}};
  localparam logic [DW-1:0] DIST_SAT = {{(DW-1){1'b1}}, 1'b0};

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]             op;
    logic [4:0]             from_vertex;
    logic [4:0]             to_vertex;
    logic [WEIGHT_BITS-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [4:0]    vertex;
    logic [DW-1:0] distance;
    logic          reachable;
    logic          has_predecessor;
    logic [4:0]    predecessor;
    logic          edges_dropped;
    logic          last;
  } out_item_t;

  typedef struct packed {
    logic [VAW-1:0]         target;
    logic [WEIGHT_BITS-1:0] cost;
    logic [EW-1:0]          link;
  } edge_t;

  typedef struct packed {
    logic           has_pred;
    logic [VAW-1:0] pred;
    logic [DW-1:0]  dval;
  } dist_t;

  typedef struct packed {
    logic [VAW-1:0] vtx;
    logic [DW-1:0]  key;
  } hent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_ADD_RD, S_ADD_WR, S_INIT, S_SRC, S_SU, S_SU_CMP,
    S_E0, S_E1, S_E2, S_EX0, S_EX1, S_EX2, S_SD, S_SD_L, S_SD_R,
    S_RLX, S_RLX2, S_OUT_RD, S_OUT_WR
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LATCH, DP_DEC, DP_ADD_RD, DP_ADD_WR, DP_INIT, DP_SRC, DP_SU,
    DP_SU_CMP, DP_E0, DP_E1, DP_E2, DP_EX0, DP_EX1, DP_EX2, DP_SD, DP_SD_L,
    DP_SD_R, DP_RLX, DP_RLX2, DP_OUT_RD, DP_OUT_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   cfg_we;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic ec_full;
    logic src_ok;
    logic init_done;
    logic i_zero;
    logic su_less;
    logic sd_leaf;
    logic sd_stay;
    logic e_end;
    logic cnt_zero;
    logic relax;
    logic out_free;
    logic out_last;
  } sts_t;
endpackage
`default_nettype wire

[sv/ssp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/ssp_ctrl.sv]
// Sequencer for graph loading, heap search and result readout.
// Depends on ssp_pkg.
`default_nettype none
module ssp_ctrl import ssp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        if (sts.op == OP_ADD && !sts.ec_full) state_nxt = S_ADD_RD;
        else if (sts.op == OP_RUN) state_nxt = S_INIT;
        else state_nxt = S_IDLE;
      end
      S_ADD_RD: state_nxt = S_ADD_WR;
      S_ADD_WR: state_nxt = S_IDLE;
      S_INIT:   if (sts.init_done) state_nxt = S_SRC;
      S_SRC:    state_nxt = sts.src_ok ? S_SU : S_E0;
      S_SU:     state_nxt = sts.i_zero ? S_E0 : S_SU_CMP;
      S_SU_CMP: state_nxt = sts.su_less ? S_SU : S_E0;
      S_E0: begin
        if (!sts.e_end) state_nxt = S_E1;
        else if (sts.cnt_zero) state_nxt = S_OUT_RD;
        else state_nxt = S_EX0;
      end
      S_E1:     state_nxt = S_E2;
      S_E2:     state_nxt = sts.relax ? S_SU : S_E0;
      S_EX0:    state_nxt = S_EX1;
      S_EX1:    state_nxt = S_EX2;
      S_EX2:    state_nxt = S_SD;
      S_SD:     state_nxt = sts.sd_leaf ? S_RLX : S_SD_L;
      S_SD_L:   state_nxt = S_SD_R;
      S_SD_R:   state_nxt = sts.sd_stay ? S_RLX : S_SD;
      S_RLX:    state_nxt = S_RLX2;
      S_RLX2:   state_nxt = S_E0;
      S_OUT_RD: state_nxt = S_OUT_WR;
      S_OUT_WR: if (sts.out_free) state_nxt = sts.out_last ? S_IDLE : S_OUT_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != S_IDLE);
    cfg_ready  = (state_r == S_IDLE);
    cmd.cfg_we = cfg_valid && (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE:   cmd.op = in_valid ? DP_LATCH : DP_NOP;
      S_DEC:    cmd.op = DP_DEC;
      S_ADD_RD: cmd.op = DP_ADD_RD;
      S_ADD_WR: cmd.op = DP_ADD_WR;
      S_INIT:   cmd.op = DP_INIT;
      S_SRC:    cmd.op = DP_SRC;
      S_SU:     cmd.op = DP_SU;
      S_SU_CMP: cmd.op = DP_SU_CMP;
      S_E0:     cmd.op = DP_E0;
      S_E1:     cmd.op = DP_E1;
      S_E2:     cmd.op = DP_E2;
      S_EX0:    cmd.op = DP_EX0;
      S_EX1:    cmd.op = DP_EX1;
      S_EX2:    cmd.op = DP_EX2;
      S_SD:     cmd.op = DP_SD;
      S_SD_L:   cmd.op = DP_SD_L;
      S_SD_R:   cmd.op = DP_SD_R;
      S_RLX:    cmd.op = DP_RLX;
      S_RLX2:   cmd.op = DP_RLX2;
      S_OUT_RD: cmd.op = DP_OUT_RD;
      S_OUT_WR: cmd.op = DP_OUT_WR;
      default:  cmd.op = DP_NOP;
    endcase
  end
endmodule
`default_nettype wire

[sv/ssp_dp.sv]
// Datapath: edge lists, distance table, indexed heap and result register.
// Depends on ssp_pkg, ssp_ram and the assertion macro header.
`default_nettype none
`include "single_source_shortest_paths_assert.svh"
module ssp_dp import ssp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire logic [5:0] cfg_data,
  input  wire cmd_t      cmd,
  output sts_t           sts,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  in_item_t  item_r;
  logic [5:0] n_r;
  logic [CW-1:0] n_use;
  logic [EW-1:0] ec_r, e_r;
  logic ovf_r;
  logic [MAX_VERTICES-1:0] hv_r;
  logic [CW-1:0] cnt_r, i_r, v_r;
  logic [VAW-1:0] cur_v_r, u_r, lv_r;
  logic [DW-1:0] cur_k_r, du_r, lk_r;
  out_item_t out_r;
  logic out_valid_r;

  // RAM ports
  logic edge_we, head_we, dist_we, heap_we, hidx_we;
  logic [EAW-1:0] edge_waddr, edge_raddr;
  logic [VAW-1:0] head_waddr, head_raddr, dist_waddr, dist_raddr;
  logic [VAW-1:0] heap_waddr, heap_raddr, hidx_waddr, hidx_raddr;
  edge_t edge_wd, edge_rd;
  logic [EW-1:0] head_wd, head_rd;
  dist_t dist_wd, dist_rd;
  hent_t heap_wd, heap_rd;
  logic [CW-1:0] hidx_wd, hidx_rd;

  // derived values
  logic [CW-1:0] p_addr;
  logic [CW:0] l_w, r_w;
  logic r_ok, sel_l, sel_r;
  logic [DW-1:0] best_k;
  hent_t child;
  logic [CW-1:0] child_i;
  logic [DW:0] sum;
  logic [DW-1:0] nd;
  logic [EW-1:0] head_val;
  logic out_free;

  assign n_use = (n_r == 6'd0) ? CW'(1) :
                 ({1'b0, n_r} > 7'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(n_r);

  assign p_addr  = (i_r - CW'(1)) >> 1;
  assign l_w     = {i_r, 1'b1};
  assign r_w     = l_w + (CW+1)'(1);
  assign r_ok    = r_w < {1'b0, cnt_r};
  assign sel_l   = lk_r < cur_k_r;
  assign best_k  = sel_l ? lk_r : cur_k_r;
  assign sel_r   = r_ok && (heap_rd.key < best_k);
  assign child   = sel_r ? heap_rd : hent_t'{vtx: lv_r, key: lk_r};
  assign child_i = sel_r ? r_w[CW-1:0] : l_w[CW-1:0];
  assign sum     = {1'b0, du_r} + (DW+1)'(edge_rd.cost);
  assign nd      = (sum >= {1'b0, DIST_INF}) ? DIST_SAT : sum[DW-1:0];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts.op        = item_r.op;
    sts.ec_full   = ec_r >= EW'(MAX_EDGES);
    sts.src_ok    = CW'(item_r.from_vertex) < n_use;
    sts.init_done = v_r == n_use - CW'(1);
    sts.i_zero    = i_r == '0;
    sts.su_less   = cur_k_r < heap_rd.key;
    sts.sd_leaf   = l_w >= {1'b0, cnt_r};
    sts.sd_stay   = !sel_l && !sel_r;
    sts.e_end     = e_r >= ec_r;
    sts.cnt_zero  = cnt_r == '0;
    sts.relax     = (CW'(edge_rd.target) < n_use) && (hidx_rd < cnt_r) &&
                    (du_r != DIST_INF) && (nd < dist_rd.dval);
    sts.out_free  = out_free;
    sts.out_last  = v_r == n_use - CW'(1);
  end

  // read addresses; the head read address holds through the add write step
  always_comb begin
    edge_raddr = e_r[EAW-1:0];
    head_raddr = (cmd.op == DP_ADD_RD || cmd.op == DP_ADD_WR) ? item_r.from_vertex : u_r;
    dist_raddr = (cmd.op == DP_E1) ? edge_rd.target :
                 (cmd.op == DP_RLX) ? u_r : v_r[VAW-1:0];
    hidx_raddr = edge_rd.target;
    case (cmd.op)
      DP_SU:   heap_raddr = p_addr[VAW-1:0];
      DP_EX1:  heap_raddr = VAW'(cnt_r - CW'(1));
      DP_SD:   heap_raddr = l_w[VAW-1:0];
      DP_SD_L: heap_raddr = r_w[VAW-1:0];
      default: heap_raddr = '0;
    endcase
  end

  assign head_val = hv_r[head_raddr] ? head_rd : NO_EDGE;

  // write ports
  always_comb begin
    edge_we = 1'b0; head_we = 1'b0; dist_we = 1'b0; heap_we = 1'b0; hidx_we = 1'b0;
    edge_waddr = ec_r[EAW-1:0];
    edge_wd    = edge_t'{target: item_r.to_vertex, cost: item_r.weight, link: head_val};
    head_waddr = item_r.from_vertex;
    head_wd    = ec_r;
    dist_waddr = v_r[VAW-1:0];
    dist_wd    = dist_t'{has_pred: 1'b0, pred: '0, dval: DIST_INF};
    heap_waddr = i_r[VAW-1:0];
    heap_wd    = hent_t'{vtx: cur_v_r, key: cur_k_r};
    hidx_waddr = cur_v_r;
    hidx_wd    = i_r;
    case (cmd.op)
      DP_ADD_WR: begin
        edge_we = 1'b1;
        head_we = 1'b1;
      end
      DP_INIT: begin
        dist_we    = 1'b1;
        heap_we    = 1'b1;
        hidx_we    = 1'b1;
        heap_waddr = v_r[VAW-1:0];
        heap_wd    = hent_t'{vtx: v_r[VAW-1:0], key: DIST_INF};
        hidx_waddr = v_r[VAW-1:0];
        hidx_wd    = v_r;
      end
      DP_SRC: begin
        dist_we    = sts.src_ok;
        dist_waddr = item_r.from_vertex;
        dist_wd    = dist_t'{has_pred: 1'b0, pred: '0, dval: '0};
      end
      DP_SU: begin
        heap_we = sts.i_zero;
        hidx_we = sts.i_zero;
      end
      DP_SU_CMP: begin
        heap_we = 1'b1;
        hidx_we = 1'b1;
        if (sts.su_less) begin
          heap_wd    = heap_rd;
          hidx_waddr = heap_rd.vtx;
        end
      end
      DP_E2: begin
        dist_we    = sts.relax;
        dist_waddr = edge_rd.target;
        dist_wd    = dist_t'{has_pred: 1'b1, pred: u_r, dval: nd};
      end
      DP_EX2: begin
        hidx_we    = 1'b1;
        hidx_waddr = u_r;
        hidx_wd    = cnt_r - CW'(1);
      end
      DP_SD: begin
        heap_we = sts.sd_leaf;
        hidx_we = sts.sd_leaf;
      end
      DP_SD_R: begin
        heap_we = 1'b1;
        hidx_we = 1'b1;
        if (!sts.sd_stay) begin
          heap_wd    = child;
          hidx_waddr = child.vtx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= 6'(MAX_VERTICES);
      ec_r        <= '0;
      ovf_r       <= 1'b0;
      hv_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_we) n_r <= cfg_data;
      if (cmd.op == DP_OUT_WR && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        DP_LATCH: begin
          item_r <= in_data;
          v_r    <= '0;
        end
        DP_DEC: begin
          if (item_r.op == OP_ADD && sts.ec_full) ovf_r <= 1'b1;
          if (item_r.op == OP_CLEAR) begin
            hv_r  <= '0;
            ec_r  <= '0;
            ovf_r <= 1'b0;
          end
        end
        DP_ADD_WR: begin
          hv_r[item_r.from_vertex] <= 1'b1;
          ec_r <= ec_r + EW'(1);
        end
        DP_INIT: begin
          v_r   <= v_r + CW'(1);
          cnt_r <= n_use;
          e_r   <= NO_EDGE;
        end
        DP_SRC: begin
          i_r     <= CW'(item_r.from_vertex);
          cur_v_r <= item_r.from_vertex;
          cur_k_r <= '0;
        end
        DP_SU_CMP: if (sts.su_less) i_r <= p_addr;
        DP_E0: v_r <= '0;
        DP_E1: e_r <= edge_rd.link;
        DP_E2: begin
          if (sts.relax) begin
            i_r     <= hidx_rd;
            cur_v_r <= edge_rd.target;
            cur_k_r <= nd;
          end
        end
        DP_EX1: u_r <= heap_rd.vtx;
        DP_EX2: begin
          cur_v_r <= heap_rd.vtx;
          cur_k_r <= heap_rd.key;
          cnt_r   <= cnt_r - CW'(1);
          i_r     <= '0;
        end
        DP_SD_L: begin
          lv_r <= heap_rd.vtx;
          lk_r <= heap_rd.key;
        end
        DP_SD_R: if (!sts.sd_stay) i_r <= child_i;
        DP_RLX2: begin
          du_r <= dist_rd.dval;
          e_r  <= head_val;
        end
        DP_OUT_WR: begin
          if (out_free) begin
            v_r                   <= v_r + CW'(1);
            out_r.vertex          <= v_r[VAW-1:0];
            out_r.reachable       <= dist_rd.dval != DIST_INF;
            out_r.distance        <= (dist_rd.dval != DIST_INF) ? dist_rd.dval : '0;
            out_r.has_predecessor <= (dist_rd.dval != DIST_INF) && dist_rd.has_pred;
            out_r.predecessor     <= ((dist_rd.dval != DIST_INF) && dist_rd.has_pred) ?
                                     dist_rd.pred : '0;
            out_r.edges_dropped   <= ovf_r;
            out_r.last            <= sts.out_last;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ssp_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk, .we(edge_we), .waddr(edge_waddr), .wdata(edge_wd),
    .raddr(edge_raddr), .rdata(edge_rd));
  ssp_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head_ram (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wd),
    .raddr(head_raddr), .rdata(head_rd));
  ssp_ram #(.WIDTH($bits(dist_t)), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk, .we(dist_we), .waddr(dist_waddr), .wdata(dist_wd),
    .raddr(dist_raddr), .rdata(dist_rd));
  ssp_ram #(.WIDTH($bits(hent_t)), .DEPTH(MAX_VERTICES)) u_heap_ram (
    .clk, .we(heap_we), .waddr(heap_waddr), .wdata(heap_wd),
    .raddr(heap_raddr), .rdata(heap_rd));
  ssp_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_hidx_ram (
    .clk, .we(hidx_we), .waddr(hidx_waddr), .wdata(hidx_wd),
    .raddr(hidx_raddr), .rdata(hidx_rd));

  `SSP_ASSERT(a_heap_bound, cnt_r <= n_use)
  `SSP_ASSERT(a_edge_bound, ec_r <= EW'(MAX_EDGES))
  `SSP_ASSERT_IMP(a_unreached, out_valid_r && !out_r.reachable, !out_r.has_predecessor)
endmodule
`default_nettype wire

[sv/single_source_shortest_paths.sv]
// Top level of the shortest-path engine: controller plus datapath.
// Depends on ssp_pkg, ssp_ctrl and ssp_dp.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_item_t (op, vertices, weight)
//   out_     output     out_valid/out_stall out_item_t (one per vertex)
//   cfg_     input      cfg_valid/cfg_ready num_vertices, 6 bits
//
// Add edge runs decode, a head read and the edge and head writes; clear, op 3 and
// a dropped edge return to idle after decode. A run initialises every vertex,
// extracts minima with sift-down, walks edges with sift-up on each relaxation,
// then reads out each vertex; every heap or table read is registered.
// Reset is synchronous, active low; edge lists come up empty, no clearing pass.
// A stalled result holds the readout sequencer; input stays stalled until done.
`default_nettype none
module single_source_shortest_paths import ssp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [5:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;

  // sequencer: one state per RAM access step
  ssp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .cfg_valid, .cfg_ready,
    .sts, .cmd);

  // tables, heap and result register
  ssp_dp u_dp (
    .clk, .rst_n, .in_data, .cfg_data, .cmd, .sts,
    .out_valid, .out_stall, .out_data);
endmodule
`default_nettype wire
